// ===== rtl/tlik_pkg.sv =====
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared types, widths and constants of the two-link leg IK pipeline.
// ----------------------------------------------------------------------------
package tlik_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TAB_LEN = 24;

	// cordic datapath and angle widths
	localparam int XY_W = 34;
	localparam int ANG_W = 33;
	localparam int LT_W = 36;

	// arctangent of 2^-i, 2^32 units per turn
	localparam logic [29:0] ATAN_TAB [TAB_LEN] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
		30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
		30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81
	};

	localparam logic signed [ANG_W-1:0] HALF_TURN = 33'sh080000000;
	localparam logic signed [LT_W-1:0] THREE_QUARTER = 36'sh0C0000000;
	localparam logic signed [XY_W-1:0] QUARTER_TURN = 34'sh040000000;
	localparam logic signed [XY_W-1:0] HALF_TURN_XY = 34'sh080000000;
	localparam logic [29:0] INV_GAIN = 30'd652032874;
	localparam logic [61:0] ONE_SQ = 62'h1000000000000000;
	localparam logic [16:0] DEG_SCALE = 17'd92160;

	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_UPPER,
		REG_LOWER,
		REG_FRONT_ORIGIN,
		REG_BACK_ORIGIN,
		REG_SPAN
	} reg_idx_t;

	localparam logic [14:0] UPPER_RST = 15'd3251;
	localparam logic [14:0] LOWER_RST = 15'd6502;
	localparam logic [8:0] FRONT_RST = 9'd240;
	localparam logic [8:0] BACK_RST = 9'd120;
	localparam logic [8:0] SPAN_RST = 9'd180;

endpackage

// ===== rtl/tlik_if.sv =====
// ----------------------------------------------------------------------------
// tlik interfaces
// Valid/ready channels for leg targets and foot results.
// ----------------------------------------------------------------------------
interface tlik_leg_if;
	logic valid;
	logic ready;
	logic signed [15:0] leg_rho;
	logic signed [15:0] leg_q;
	logic signed [15:0] leg_theta;
	modport source (output valid, leg_rho, leg_q, leg_theta, input ready);
	modport sink (input valid, leg_rho, leg_q, leg_theta, output ready);
endinterface

interface tlik_foot_if;
	logic valid;
	logic ready;
	logic signed [15:0] foot_x;
	logic signed [15:0] foot_z;
	logic [16:0] front_servo_deg;
	logic [16:0] back_servo_deg;
	logic reach_fault;
	modport source (output valid, foot_x, foot_z, front_servo_deg, back_servo_deg,
		reach_fault, input ready);
	modport sink (input valid, foot_x, foot_z, front_servo_deg, back_servo_deg,
		reach_fault, output ready);
endinterface

// ===== rtl/tlik_delay.sv =====
// ----------------------------------------------------------------------------
// tlik_delay
// Enabled shift line that keeps side data in step with the pipeline.
// ----------------------------------------------------------------------------
module tlik_delay #(
	parameter int W = 8,
	parameter int D = 1
) (
	input logic clk,
	input logic en,
	input logic [W-1:0] din,
	output logic [W-1:0] dout
);
	if (D == 0) begin : g_none
		assign dout = din;
	end else begin : g_line
		logic [W-1:0] line_s [D];
		always_ff @(posedge clk) begin
			if (en) begin
				line_s[0] <= din;
				for (int k = 1; k < D; k++) line_s[k] <= line_s[k-1];
			end
		end
		assign dout = line_s[D-1];
	end
endmodule

// ===== rtl/tlik_isqrt.sv =====
// ----------------------------------------------------------------------------
// tlik_isqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tlik_isqrt #(
	parameter int RW = 16
) (
	input logic clk,
	input logic en,
	input logic [2*RW-1:0] rad,
	output logic [RW-1:0] root
);
	logic [RW+1:0] rem_s [RW];
	logic [RW-1:0] root_s [RW];
	logic [2*RW-1:0] rad_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RW+1:0] rem_in;
		logic [RW+1:0] rem_sh;
		logic [RW+1:0] trial;
		logic [RW-1:0] root_in;
		logic [2*RW-1:0] rad_in;
		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign root_in = '0;
			assign rad_in = rad;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in = rad_s[k-1];
		end
		assign rem_sh = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
		assign trial = {root_in, 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_sh >= trial) begin
					rem_s[k] <= rem_sh - trial;
					root_s[k] <= {root_in[RW-2:0], 1'b1};
				end else begin
					rem_s[k] <= rem_sh;
					root_s[k] <= {root_in[RW-2:0], 1'b0};
				end
				rad_s[k] <= {rad_in[2*RW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[RW-1];
endmodule

// ===== rtl/tlik_div.sv =====
// ----------------------------------------------------------------------------
// tlik_div
// Pipelined restoring divider for mag*2^(QW-1)/den with mag <= den.
// ----------------------------------------------------------------------------
module tlik_div #(
	parameter int NW = 32,
	parameter int QW = 31
) (
	input logic clk,
	input logic en,
	input logic [NW-1:0] mag,
	input logic [NW-1:0] den,
	output logic [QW-1:0] quot
);
	logic [NW-1:0] rem_s [QW];
	logic [NW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [NW:0] part;
		logic [NW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic ge;
		if (k == 0) begin : g_first
			assign part = {1'b0, mag};
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign part = {rem_s[k-1], 1'b0};
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end
		assign ge = part >= {1'b0, den_in};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? NW'(part - {1'b0, den_in}) : part[NW-1:0];
				den_s[k] <= den_in;
				quo_s[k] <= {quo_in[QW-2:0], ge};
			end
		end
	end

	assign quot = quo_s[QW-1];
endmodule

// ===== rtl/tlik_cordic_vec.sv =====
// ----------------------------------------------------------------------------
// tlik_cordic_vec
// Pipelined vectoring cordic giving atan2(y, x), 2^32 units per turn.
// ----------------------------------------------------------------------------
module tlik_cordic_vec #(
	parameter int STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic en,
	input logic signed [tlik_pkg::XY_W-1:0] y,
	input logic signed [tlik_pkg::XY_W-1:0] x,
	output logic signed [tlik_pkg::ANG_W-1:0] ang
);
	localparam int W = tlik_pkg::XY_W;
	localparam int AW = tlik_pkg::ANG_W;

	logic signed [W-1:0] x_s [STAGES+1];
	logic signed [W-1:0] y_s [STAGES+1];
	logic signed [AW-1:0] z_s [STAGES+1];
	logic zero_s [STAGES+1];

	// half-plane fold
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x == '0) && (y == '0);
			if (x < 0) begin
				x_s[0] <= -x;
				y_s[0] <= -y;
				z_s[0] <= (y >= 0) ? tlik_pkg::HALF_TURN : -tlik_pkg::HALF_TURN;
			end else begin
				x_s[0] <= x;
				y_s[0] <= y;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		localparam logic signed [AW-1:0] TAB_I = AW'(tlik_pkg::ATAN_TAB[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + TAB_I;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - TAB_I;
				end
			end
		end
	end

	assign ang = zero_s[STAGES] ? '0 : z_s[STAGES];
endmodule

// ===== rtl/tlik_cordic_rot.sv =====
// ----------------------------------------------------------------------------
// tlik_cordic_rot
// Pipelined rotation cordic turning (reach, 0) into the saturated foot point.
// ----------------------------------------------------------------------------
module tlik_cordic_rot #(
	parameter int STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic en,
	input logic [15:0] reach,
	input logic [31:0] ang,
	output logic signed [15:0] foot_x,
	output logic signed [15:0] foot_z
);
	localparam int W = tlik_pkg::XY_W;

	logic signed [W-1:0] x_s [STAGES+1];
	logic signed [W-1:0] y_s [STAGES+1];
	logic signed [W-1:0] s_s [STAGES+1];
	logic signed [15:0] fx_s;
	logic signed [15:0] fz_s;

	logic [45:0] prod;
	logic signed [W-1:0] x0;
	logic signed [W-1:0] a0;
	logic signed [W-1:0] xr;
	logic signed [W-1:0] zr;

	assign prod = 46'({30'd0, reach} * {16'd0, tlik_pkg::INV_GAIN});
	assign x0 = $signed({2'b00, prod[45:14]});
	assign a0 = $signed({{2{ang[31]}}, ang});

	// quadrant fold
	always_ff @(posedge clk) begin
		if (en) begin
			y_s[0] <= '0;
			if (a0 > tlik_pkg::QUARTER_TURN) begin
				x_s[0] <= -x0;
				s_s[0] <= a0 - tlik_pkg::HALF_TURN_XY;
			end else if (a0 < -tlik_pkg::QUARTER_TURN) begin
				x_s[0] <= -x0;
				s_s[0] <= a0 + tlik_pkg::HALF_TURN_XY;
			end else begin
				x_s[0] <= x0;
				s_s[0] <= a0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		localparam logic signed [W-1:0] TAB_I = W'(tlik_pkg::ATAN_TAB[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				if (s_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					s_s[i+1] <= s_s[i] - TAB_I;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					s_s[i+1] <= s_s[i] + TAB_I;
				end
			end
		end
	end

	// round half up to Q8.8 and saturate
	assign xr = (x_s[STAGES] + 34'sd32768) >>> 16;
	assign zr = (y_s[STAGES] + 34'sd32768) >>> 16;

	always_ff @(posedge clk) begin
		if (en) begin
			if (xr > 34'sd32767) fx_s <= 16'sh7FFF;
			else if (xr < -34'sd32768) fx_s <= 16'sh8000;
			else fx_s <= xr[15:0];
			if (zr > 34'sd32767) fz_s <= 16'sh7FFF;
			else if (zr < -34'sd32768) fz_s <= 16'sh8000;
			else fz_s <= zr[15:0];
		end
	end

	assign foot_x = fx_s;
	assign foot_z = fz_s;
endmodule

// ===== rtl/two_link_leg_inverse_kinematics_unit.sv =====
// ----------------------------------------------------------------------------
// two_link_leg_inverse_kinematics_unit
// Leg target to foot point and servo angles, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one target word per cycle while the result side does not stall, and
// returns one result word per target. The latency is set by the chain of the
// reach square root, the 31-stage cosine divider, the 31-stage sine square
// root and the two cordic pipelines. When the result side stalls, every stage
// holds; registers may be written over the APB port only while the pipeline
// is empty.
module two_link_leg_inverse_kinematics_unit #(
	parameter int CORDIC_STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	tlik_leg_if.sink leg_in,
	tlik_foot_if.source leg_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [tlik_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int CS = CORDIC_STAGES;
	localparam int LA = (CS + 1 > 16) ? CS + 1 : 16;
	localparam int TOTAL = LA + CS + 70;

	// configuration registers
	logic [14:0] upper_q;
	logic [14:0] lower_q;
	logic [8:0] front_q;
	logic [8:0] back_q;
	logic [8:0] span_q;
	tlik_pkg::reg_idx_t widx;

	assign pready = 1'b1;
	assign widx = tlik_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= tlik_pkg::UPPER_RST;
			lower_q <= tlik_pkg::LOWER_RST;
			front_q <= tlik_pkg::FRONT_RST;
			back_q <= tlik_pkg::BACK_RST;
			span_q <= tlik_pkg::SPAN_RST;
		end else if (psel && penable && pwrite) begin
			case (widx)
				tlik_pkg::REG_UPPER: upper_q <= pwdata[14:0];
				tlik_pkg::REG_LOWER: lower_q <= pwdata[14:0];
				tlik_pkg::REG_FRONT_ORIGIN: front_q <= pwdata[8:0];
				tlik_pkg::REG_BACK_ORIGIN: back_q <= pwdata[8:0];
				tlik_pkg::REG_SPAN: span_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			tlik_pkg::REG_UPPER: prdata = {17'd0, upper_q};
			tlik_pkg::REG_LOWER: prdata = {17'd0, lower_q};
			tlik_pkg::REG_FRONT_ORIGIN: prdata = {23'd0, front_q};
			tlik_pkg::REG_BACK_ORIGIN: prdata = {23'd0, back_q};
			tlik_pkg::REG_SPAN: prdata = {23'd0, span_q};
			default: prdata = '0;
		endcase
	end

	// pipeline advance and valid line
	logic en;
	logic [TOTAL-1:0] vld_q;

	assign en = !vld_q[TOTAL-1] || leg_out.ready;
	assign leg_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[TOTAL-2:0], leg_in.valid};
	end

	// stage 1: capture and square
	logic signed [15:0] rho_s1;
	logic signed [15:0] q_s1;
	logic signed [15:0] th_s1;
	logic signed [31:0] rsq_s1;
	logic signed [31:0] qsq_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			rho_s1 <= leg_in.leg_rho;
			q_s1 <= leg_in.leg_q;
			th_s1 <= leg_in.leg_theta;
			rsq_s1 <= leg_in.leg_rho * leg_in.leg_rho;
			qsq_s1 <= leg_in.leg_q * leg_in.leg_q;
		end
	end

	logic [31:0] rad1;
	logic [15:0] reach;
	logic signed [tlik_pkg::ANG_W-1:0] foot_ang;

	assign rad1 = {1'b0, rsq_s1[30:0]} + {1'b0, qsq_s1[30:0]};

	tlik_isqrt #(.RW(16)) u_reach_sqrt (
		.clk(clk), .en(en), .rad(rad1), .root(reach)
	);

	tlik_cordic_vec #(.STAGES(CS)) u_foot_atan (
		.clk(clk), .en(en),
		.y($signed({{4{q_s1[15]}}, q_s1, 14'd0})),
		.x($signed({{4{rho_s1[15]}}, rho_s1, 14'd0})),
		.ang(foot_ang)
	);

	logic [15:0] reach_d;
	logic [tlik_pkg::ANG_W-1:0] ang_d;
	logic [15:0] th_d;

	tlik_delay #(.W(16), .D(LA - 16)) u_reach_dly (
		.clk(clk), .en(en), .din(reach), .dout(reach_d)
	);
	tlik_delay #(.W(tlik_pkg::ANG_W), .D(LA - CS - 1)) u_ang_dly (
		.clk(clk), .en(en), .din(foot_ang), .dout(ang_d)
	);
	tlik_delay #(.W(16), .D(LA)) u_th_dly (
		.clk(clk), .en(en), .din(th_s1), .dout(th_d)
	);

	// stage 2: leg angle and products
	logic signed [tlik_pkg::LT_W-1:0] lt_s2;
	logic [30:0] ur_s2;
	logic [29:0] uu_s2;
	logic [31:0] rr_s2;
	logic [29:0] ll_s2;
	logic [15:0] reach_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			lt_s2 <= $signed({{3{ang_d[32]}}, ang_d})
				+ $signed({{4{th_d[15]}}, th_d, 16'd0}) + tlik_pkg::THREE_QUARTER;
			ur_s2 <= 31'({16'd0, upper_q} * {15'd0, reach_d});
			uu_s2 <= 30'({15'd0, upper_q} * {15'd0, upper_q});
			rr_s2 <= 32'({16'd0, reach_d} * {16'd0, reach_d});
			ll_s2 <= 30'({15'd0, lower_q} * {15'd0, lower_q});
			reach_s2 <= reach_d;
		end
	end

	// stage 3: numerator, denominator and clamp
	logic signed [33:0] num;
	logic [33:0] absn;
	logic [31:0] den;
	logic over;
	logic [31:0] mag_s3;
	logic [31:0] den_s3;
	logic neg_s3;
	logic fault_s3;
	logic dzero_s3;

	assign num = $signed({4'd0, uu_s2}) + $signed({2'd0, rr_s2}) - $signed({4'd0, ll_s2});
	assign absn = num[33] ? 34'(-num) : num;
	assign den = {ur_s2, 1'b0};
	assign over = absn[32:0] > {1'b0, den};

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3 <= over ? den : absn[31:0];
			den_s3 <= den;
			neg_s3 <= num[33];
			dzero_s3 <= den == '0;
			fault_s3 <= (den == '0) || over;
		end
	end

	logic [30:0] quot;
	logic neg_d;

	tlik_div #(.NW(32), .QW(31)) u_cos_div (
		.clk(clk), .en(en), .mag(mag_s3), .den(den_s3), .quot(quot)
	);
	tlik_delay #(.W(1), .D(31)) u_neg_dly (
		.clk(clk), .en(en), .din(neg_s3), .dout(neg_d)
	);

	// stage 4: signed cosine and its square
	logic signed [31:0] c_s4;
	logic [61:0] csq_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s4 <= neg_d ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
			csq_s4 <= 62'({31'd0, quot} * {31'd0, quot});
		end
	end

	logic [30:0] sine;
	logic [31:0] c_d;
	logic signed [tlik_pkg::ANG_W-1:0] off;

	tlik_isqrt #(.RW(31)) u_sine_sqrt (
		.clk(clk), .en(en), .rad(tlik_pkg::ONE_SQ - csq_s4), .root(sine)
	);
	tlik_delay #(.W(32), .D(31)) u_cos_dly (
		.clk(clk), .en(en), .din(c_s4), .dout(c_d)
	);
	tlik_cordic_vec #(.STAGES(CS)) u_off_atan (
		.clk(clk), .en(en),
		.y($signed({3'd0, sine})),
		.x($signed({{2{c_d[31]}}, c_d})),
		.ang(off)
	);

	logic [1:0] flags_d;
	logic [tlik_pkg::LT_W-1:0] lt_d;

	tlik_delay #(.W(2), .D(CS + 64)) u_flag_dly (
		.clk(clk), .en(en), .din({fault_s3, dzero_s3}), .dout(flags_d)
	);
	tlik_delay #(.W(tlik_pkg::LT_W), .D(CS + 65)) u_lt_dly (
		.clk(clk), .en(en), .din(lt_s2), .dout(lt_d)
	);

	// foot point
	logic signed [15:0] fx;
	logic signed [15:0] fz;
	logic [31:0] foot_d;

	tlik_cordic_rot #(.STAGES(CS)) u_foot_rot (
		.clk(clk), .en(en), .reach(reach_s2), .ang(lt_s2[31:0]),
		.foot_x(fx), .foot_z(fz)
	);
	tlik_delay #(.W(32), .D(65)) u_foot_dly (
		.clk(clk), .en(en), .din({fx, fz}), .dout(foot_d)
	);

	// stage 5: servo angles wrapped to non-negative
	logic signed [tlik_pkg::ANG_W-1:0] offe;
	logic signed [36:0] vf;
	logic signed [36:0] vb;
	logic [33:0] vf_s5;
	logic [33:0] vb_s5;
	logic fault_s5;

	assign offe = flags_d[0] ? '0 : off;
	assign vf = $signed({lt_d[35], lt_d}) + $signed({{4{offe[32]}}, offe});
	assign vb = $signed({lt_d[35], lt_d}) - $signed({{4{offe[32]}}, offe});

	always_ff @(posedge clk) begin
		if (en) begin
			vf_s5 <= vf[36] ? {2'd0, vf[31:0]} : vf[33:0];
			vb_s5 <= vb[36] ? {2'd0, vb[31:0]} : vb[33:0];
			fault_s5 <= flags_d[1];
		end
	end

	// stage 6: scale to Q11.8 degrees in bits 50:32
	logic [50:0] pf_s6;
	logic [50:0] pb_s6;
	logic fault_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			pf_s6 <= 51'({17'd0, vf_s5} * {34'd0, tlik_pkg::DEG_SCALE});
			pb_s6 <= 51'({17'd0, vb_s5} * {34'd0, tlik_pkg::DEG_SCALE});
			fault_s6 <= fault_s5;
		end
	end

	function automatic logic [16:0] servo_clamp(
		input logic [18:0] deg,
		input logic [8:0] origin,
		input logic [8:0] span
	);
		logic signed [20:0] d;
		logic signed [20:0] hi;
		d = $signed({2'd0, deg}) - $signed({4'd0, origin, 8'd0});
		hi = $signed({4'd0, span, 8'd0});
		if (d < 0) return '0;
		else if (d > hi) return hi[16:0];
		else return d[16:0];
	endfunction

	// stage 7: origin, clamp and output
	logic [16:0] front_s7;
	logic [16:0] back_s7;
	logic [31:0] foot_s7;
	logic fault_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			front_s7 <= servo_clamp(pf_s6[50:32], front_q, span_q);
			back_s7 <= servo_clamp(pb_s6[50:32], back_q, span_q);
			foot_s7 <= foot_d;
			fault_s7 <= fault_s6;
		end
	end

	assign leg_out.valid = vld_q[TOTAL-1];
	assign leg_out.foot_x = foot_s7[31:16];
	assign leg_out.foot_z = foot_s7[15:0];
	assign leg_out.front_servo_deg = front_s7;
	assign leg_out.back_servo_deg = back_s7;
	assign leg_out.reach_fault = fault_s7;
endmodule
